### sv/stok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared widths, token kind codes, error codes, result types and the
// keyword table used by the tokenizer and its checker.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int LINE_BITS   = 20;
  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;
  localparam int KW_CHARS    = 8;
  localparam int KW_COUNT    = 14;
  localparam int PREFIX_BITS = 8 * KW_CHARS;

  // Token kinds. Keywords take codes 0 to KW_COUNT-1 in table order.
  localparam logic [5:0] K_IDENT   = 6'd14;
  localparam logic [5:0] K_NUM     = 6'd15;
  localparam logic [5:0] K_STR     = 6'd16;
  localparam logic [5:0] K_CHR     = 6'd17;
  localparam logic [5:0] K_PLUS    = 6'd18;
  localparam logic [5:0] K_MINUS   = 6'd19;
  localparam logic [5:0] K_STAR    = 6'd20;
  localparam logic [5:0] K_PCT     = 6'd21;
  localparam logic [5:0] K_DIV     = 6'd22;
  localparam logic [5:0] K_NOT     = 6'd23;
  localparam logic [5:0] K_NE      = 6'd24;
  localparam logic [5:0] K_AND     = 6'd25;
  localparam logic [5:0] K_OR      = 6'd26;
  localparam logic [5:0] K_ASSIGN  = 6'd27;
  localparam logic [5:0] K_EQ      = 6'd28;
  localparam logic [5:0] K_GT      = 6'd29;
  localparam logic [5:0] K_GE      = 6'd30;
  localparam logic [5:0] K_LT      = 6'd31;
  localparam logic [5:0] K_LE      = 6'd32;
  localparam logic [5:0] K_LPAR    = 6'd33;
  localparam logic [5:0] K_RPAR    = 6'd34;
  localparam logic [5:0] K_LBRK    = 6'd35;
  localparam logic [5:0] K_RBRK    = 6'd36;
  localparam logic [5:0] K_LBRC    = 6'd37;
  localparam logic [5:0] K_RBRC    = 6'd38;
  localparam logic [5:0] K_SEMI    = 6'd39;
  localparam logic [5:0] K_COMMA   = 6'd40;
  localparam logic [5:0] K_UNKNOWN = 6'd41;
  localparam logic [5:0] K_END     = 6'd42;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_AMP     = 2'd1;
  localparam logic [1:0] ERR_BAR     = 2'd2;
  localparam logic [1:0] ERR_UNTERM  = 2'd3;

  // Keyword text, first character in the lowest byte, zero padded.
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0074_6e69,  // int
    64'h0000_0000_7261_6863,  // char
    64'h0000_0000_6469_6f76,  // void
    64'h0000_0074_736e_6f63,  // const
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0000_0072_6f66,  // for
    64'h0000_006b_6165_7262,  // break
    64'h6575_6e69_746e_6f63,  // continue
    64'h0000_6e72_7574_6572,  // return
    64'h0000_6674_6e69_7270,  // printf
    64'h0000_746e_6974_6567,  // getint
    64'h0072_6168_6374_6567,  // getchar
    64'h0000_0000_6e69_616d   // main
  };

  typedef struct packed {
    logic [5:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [1:0]             err;
    logic                   done;
  } stok_res_t;

  // Results produced by one accepted byte, packed to the low slots.
  typedef struct packed {
    logic [1:0]            cnt;
    stok_res_t [2:0]       res;
  } stok_push_t;

  function automatic logic [5:0] kw_kind(input logic [PREFIX_BITS-1:0] prefix,
                                         input logic [LENGTH_BITS-1:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= LENGTH_BITS'(KW_CHARS)) begin
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
        if (prefix == KW_TEXT[i]) k = 6'(i);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/stok_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer lexer core
// Holds the scanner state and works out, for each accepted byte, the next
// state and up to three results in one combinational pass.
// ----------------------------------------------------------------------------
module stok_lexer import stok_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       last_i,
  output stok_push_t      push_o
);

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SLASH = 4'd1;
  localparam logic [3:0] M_LCOM  = 4'd2;
  localparam logic [3:0] M_BCOM  = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_OP    = 4'd5;
  localparam logic [3:0] M_NUM   = 4'd6;
  localparam logic [3:0] M_IDENT = 4'd7;
  localparam logic [3:0] M_STR   = 4'd8;
  localparam logic [3:0] M_CHA   = 4'd9;
  localparam logic [3:0] M_CHC   = 4'd10;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_RBRC  = 8'h7d;

  logic [3:0]             mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic [LENGTH_BITS-1:0] tlen_q, tlen_d;
  logic [7:0]             held_q, held_d;
  logic [PREFIX_BITS-1:0] prefix_q, prefix_d;
  logic                   esc_q, esc_d;

  stok_res_t              cand [4];
  logic [3:0]             cand_v;
  logic                   to_idle;
  logic                   clear_held;
  logic                   is_digit, is_alpha, is_break;
  logic [5:0]             pair_kind;
  logic [7:0]             held_op, cur_op;
  logic [2:0]             n;

  function automatic stok_res_t mk_res(input logic [5:0] kind,
                                       input logic [LINE_BITS-1:0] line,
                                       input logic [OFFSET_BITS-1:0] start,
                                       input logic [LENGTH_BITS-1:0] len,
                                       input logic [1:0] err,
                                       input logic done);
    stok_res_t r;
    r.kind  = kind;
    r.line  = line;
    r.start = start;
    r.len   = len;
    r.err   = err;
    r.done  = done;
    return r;
  endfunction

  // Single-character operator for a held operator byte: {error, kind}.
  function automatic logic [7:0] op_single(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      CH_AMP:  r = {ERR_AMP,  K_AND};
      CH_BAR:  r = {ERR_BAR,  K_OR};
      CH_EQ:   r = {ERR_NONE, K_ASSIGN};
      CH_GT:   r = {ERR_NONE, K_GT};
      CH_LT:   r = {ERR_NONE, K_LT};
      default: r = {ERR_NONE, K_NOT};
    endcase
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] len);
    return (len != '1) ? len + 1'b1 : len;
  endfunction

  assign is_digit = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign is_alpha = ((ch_i >= 8'h61) && (ch_i <= 8'h7a)) ||
                    ((ch_i >= 8'h41) && (ch_i <= 8'h5a)) || (ch_i == 8'h5f);
  // CR LF counts once: LF after CR is not a new break.
  assign is_break = (ch_i == CH_CR) || ((ch_i == CH_LF) && (held_q != CH_CR));
  assign held_op  = op_single(held_q);
  assign cur_op   = op_single(ch_i);

  always_comb begin
    pair_kind = '0;
    if (ch_i == CH_EQ) begin
      case (held_q)
        CH_BANG: pair_kind = K_NE;
        CH_EQ:   pair_kind = K_EQ;
        CH_GT:   pair_kind = K_GE;
        CH_LT:   pair_kind = K_LE;
        default: pair_kind = '0;
      endcase
    end
    if ((held_q == CH_AMP) && (ch_i == CH_AMP)) pair_kind = K_AND;
    if ((held_q == CH_BAR) && (ch_i == CH_BAR)) pair_kind = K_OR;
  end

  always_comb begin
    mode_d     = mode_q;
    line_d     = line_q;
    tstart_d   = tstart_q;
    tlen_d     = tlen_q;
    prefix_d   = prefix_q;
    esc_d      = esc_q;
    to_idle    = 1'b0;
    clear_held = 1'b0;
    cand_v     = '0;
    for (int i = 0; i < 4; i++) cand[i] = '0;

    // Step one: the byte continues or closes the open construct.
    unique case (mode_q)
      M_NUM: begin
        if (is_digit) begin
          tlen_d = grow(tlen_q);
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_res(K_NUM, line_q, tstart_q, tlen_q, ERR_NONE, 1'b0);
          to_idle   = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha || is_digit) begin
          if (tlen_q < LENGTH_BITS'(KW_CHARS)) begin
            for (int j = 0; j < KW_CHARS; j++) begin
              if (tlen_q[$clog2(KW_CHARS)-1:0] == $clog2(KW_CHARS)'(j)) begin
                prefix_d[8*j +: 8] = prefix_q[8*j +: 8] | ch_i;
              end
            end
          end
          tlen_d = grow(tlen_q);
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_res(kw_kind(prefix_q, tlen_q), line_q, tstart_q, tlen_q,
                             ERR_NONE, 1'b0);
          to_idle   = 1'b1;
        end
      end
      M_OP: begin
        cand_v[0] = 1'b1;
        if (pair_kind != '0) begin
          cand[0] = mk_res(pair_kind, line_q, tstart_q, LENGTH_BITS'(2), ERR_NONE, 1'b0);
          mode_d  = M_IDLE;
        end else begin
          cand[0] = mk_res(held_op[5:0], line_q, tstart_q, LENGTH_BITS'(1),
                           held_op[7:6], 1'b0);
          to_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch_i == CH_SLASH) begin
          mode_d = M_LCOM;
        end else if (ch_i == CH_STAR) begin
          mode_d = M_BCOM;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_res(K_DIV, line_q, tstart_q, LENGTH_BITS'(1), ERR_NONE, 1'b0);
          to_idle   = 1'b1;
        end
      end
      M_LCOM: begin
        if ((ch_i == CH_CR) || (ch_i == CH_LF)) to_idle = 1'b1;
      end
      M_BCOM, M_BSTAR: begin
        if ((mode_q == M_BSTAR) && (ch_i == CH_SLASH)) begin
          mode_d = M_IDLE;
        end else if (ch_i == CH_STAR) begin
          mode_d = M_BSTAR;
        end else begin
          mode_d = M_BCOM;
          if (is_break && (line_q != '1)) line_d = line_q + 1'b1;
        end
      end
      M_STR: begin
        tlen_d = grow(tlen_q);
        if (ch_i == CH_DQ) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_res(K_STR, line_q, tstart_q, grow(tlen_q), ERR_NONE, 1'b0);
          mode_d    = M_IDLE;
        end
      end
      M_CHA: begin
        tlen_d = grow(tlen_q);
        esc_d  = (ch_i == CH_BSL);
        mode_d = M_CHC;
      end
      M_CHC: begin
        tlen_d = grow(tlen_q);
        if (esc_q) begin
          esc_d = 1'b0;
        end else begin
          cand_v[0]  = 1'b1;
          cand[0]    = mk_res(K_CHR, line_q, tstart_q, grow(tlen_q), ERR_NONE, 1'b0);
          mode_d     = M_IDLE;
          clear_held = 1'b1;
        end
      end
      default: to_idle = 1'b1;
    endcase

    // Step two: the byte starts something new from the idle state.
    if (to_idle) begin
      mode_d = M_IDLE;
      cand[1] = mk_res(K_UNKNOWN, line_q, off_q, LENGTH_BITS'(1), ERR_NONE, 1'b0);
      case (ch_i) inside
        CH_SP, CH_TAB, CH_BS: ;
        CH_CR, CH_LF: begin
          if (is_break && (line_q != '1)) line_d = line_q + 1'b1;
        end
        CH_SLASH: begin
          mode_d   = M_SLASH;
          tstart_d = off_q;
        end
        CH_BANG, CH_AMP, CH_BAR, CH_EQ, CH_GT, CH_LT: begin
          mode_d   = M_OP;
          tstart_d = off_q;
        end
        CH_DQ: begin
          mode_d   = M_STR;
          tstart_d = off_q;
          tlen_d   = LENGTH_BITS'(1);
        end
        CH_SQ: begin
          mode_d   = M_CHA;
          tstart_d = off_q;
          tlen_d   = LENGTH_BITS'(1);
          esc_d    = 1'b0;
        end
        CH_PLUS:  begin cand_v[1] = 1'b1; cand[1].kind = K_PLUS;  end
        CH_MINUS: begin cand_v[1] = 1'b1; cand[1].kind = K_MINUS; end
        CH_STAR:  begin cand_v[1] = 1'b1; cand[1].kind = K_STAR;  end
        CH_PCT:   begin cand_v[1] = 1'b1; cand[1].kind = K_PCT;   end
        CH_LPAR:  begin cand_v[1] = 1'b1; cand[1].kind = K_LPAR;  end
        CH_RPAR:  begin cand_v[1] = 1'b1; cand[1].kind = K_RPAR;  end
        CH_LBRK:  begin cand_v[1] = 1'b1; cand[1].kind = K_LBRK;  end
        CH_RBRK:  begin cand_v[1] = 1'b1; cand[1].kind = K_RBRK;  end
        CH_LBRC:  begin cand_v[1] = 1'b1; cand[1].kind = K_LBRC;  end
        CH_RBRC:  begin cand_v[1] = 1'b1; cand[1].kind = K_RBRC;  end
        CH_SEMI:  begin cand_v[1] = 1'b1; cand[1].kind = K_SEMI;  end
        CH_COMMA: begin cand_v[1] = 1'b1; cand[1].kind = K_COMMA; end
        default: begin
          if (is_digit) begin
            mode_d   = M_NUM;
            tstart_d = off_q;
            tlen_d   = LENGTH_BITS'(1);
          end else if (is_alpha) begin
            mode_d   = M_IDENT;
            tstart_d = off_q;
            tlen_d   = LENGTH_BITS'(1);
            prefix_d = PREFIX_BITS'(ch_i);
          end else begin
            cand_v[1] = 1'b1;
          end
        end
      endcase
    end

    held_d = clear_held ? 8'h00 : ch_i;
    off_d  = off_q + 1'b1;

    // Step three: at the final byte flush what is open, then the end marker.
    if (last_i) begin
      cand_v[3] = 1'b1;
      cand[3]   = mk_res(K_END, line_d, off_d, '0, ERR_NONE, 1'b1);
      case (mode_d)
        M_NUM: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_res(K_NUM, line_d, tstart_d, tlen_d, ERR_NONE, 1'b0);
        end
        M_IDENT: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_res(kw_kind(prefix_d, tlen_d), line_d, tstart_d, tlen_d,
                             ERR_NONE, 1'b0);
        end
        M_OP: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_res(cur_op[5:0], line_d, tstart_d, LENGTH_BITS'(1),
                             cur_op[7:6], 1'b0);
        end
        M_SLASH: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_res(K_DIV, line_d, tstart_d, LENGTH_BITS'(1), ERR_NONE, 1'b0);
        end
        M_BCOM, M_BSTAR, M_STR, M_CHA, M_CHC: begin
          cand[3].err   = ERR_UNTERM;
          cand[3].start = tstart_d;
        end
        default: ;
      endcase
      mode_d   = M_IDLE;
      line_d   = LINE_BITS'(1);
      off_d    = '0;
      tstart_d = '0;
      tlen_d   = '0;
      held_d   = '0;
      prefix_d = '0;
      esc_d    = 1'b0;
    end
  end

  // Pack the valid results into the low slots, keeping their order.
  always_comb begin
    n = '0;
    push_o.res = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n < 3'd3) push_o.res[n[1:0]] = cand[i];
        n = n + 1'b1;
      end
    end
    push_o.cnt = n[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      line_q   <= LINE_BITS'(1);
      off_q    <= '0;
      tstart_q <= '0;
      tlen_q   <= '0;
      held_q   <= '0;
      prefix_q <= '0;
      esc_q    <= 1'b0;
    end else if (acc_i) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      off_q    <= off_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      held_q   <= held_d;
      prefix_q <= prefix_d;
      esc_q    <= esc_d;
    end
  end

endmodule
`default_nettype wire

### sv/stok_res_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer result queue
// Four-entry queue that takes up to three results in one cycle and hands
// them out one per transfer.
// ----------------------------------------------------------------------------
module stok_res_fifo import stok_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire stok_push_t push_data_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output stok_res_t       out_data_o
);

  stok_res_t  mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] count_q;
  logic [1:0] push_cnt;
  logic       pop;

  assign push_cnt    = push_i ? push_data_i.cnt : 2'd0;
  assign out_valid_o = (count_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];
  // A byte may bring three results, so input waits until three slots are free.
  assign room_o      = (count_q <= 3'd1);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt) mem_q[wptr_q + 2'(i)] <= push_data_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + push_cnt;
      rptr_q  <= rptr_q + 2'(pop);
      count_q <= count_q + 3'(push_cnt) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/source_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexer for a small C subset, one source byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while the queue has room and
// scans it in a single pass from the lexer state registers; the tokens it
// completes are written to a four-entry result queue and leave it one token
// per output transfer. Most bytes give at most one token, so with the output
// ready a steady stream runs at one byte per cycle. A byte that ends a token
// and starts a one-character token, or the final byte with its flush and end
// marker, gives two or three tokens; input then pauses until the queue is
// down to one entry, so the output port's one token per cycle sets the pace.
// After the byte flagged as last the block returns to its reset state and the
// next byte starts a new buffer at offset 0, line 1.
module source_tokenizer import stok_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [7:0]             ch_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [5:0]                  kind_o,
  output logic [LINE_BITS-1:0]        line_o,
  output logic [OFFSET_BITS-1:0]      start_res_o,
  output logic [LENGTH_BITS-1:0]      length_o,
  output logic [1:0]                  error_o,
  output logic                        done_res_o
);

  logic       acc;
  logic       room;
  stok_push_t push;
  stok_res_t  res;

  assign in_ready_o = room;
  assign acc        = in_valid_i && room;

  stok_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .ch_i   (ch_i),
    .last_i (last_i),
    .push_o (push)
  );

  stok_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .push_data_i (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  assign kind_o      = res.kind;
  assign line_o      = res.line;
  assign start_res_o = res.start;
  assign length_o    = res.len;
  assign error_o     = res.err;
  assign done_res_o  = res.done;

endmodule
`default_nettype wire

### sv/stok_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer port checker
// Watches the top-level ports for result consistency and output handshake.
// ----------------------------------------------------------------------------
module stok_checker import stok_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [5:0]             kind_o,
  input wire logic [LENGTH_BITS-1:0] length_o,
  input wire logic [1:0]             error_o,
  input wire logic                   done_res_o
);

  // A stalled result keeps its kind until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("result changed while stalled");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> kind_o == K_END && length_o == '0)
    else $error("end result malformed");

  a_unterm_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> error_o != ERR_UNTERM && kind_o != K_END)
    else $error("end-only fields on an ordinary token");

  a_lone_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o == ERR_AMP || error_o == ERR_BAR) |->
      length_o == LENGTH_BITS'(1) && (kind_o == K_AND || kind_o == K_OR))
    else $error("lone operator flag on a wrong token");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .length_o    (length_o),
  .error_o     (error_o),
  .done_res_o  (done_res_o)
);
`default_nettype wire

### tb/source_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Streams byte buffers into the tokenizer with random gaps on both handshakes
// and checks each token, field by field, against a software lexer that runs
// on every accepted byte.
// ----------------------------------------------------------------------------
module source_tokenizer_test;
  import stok_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_LINE_CMT, SC_BLOCK_CMT, SC_BLOCK_STAR, SC_OP,
    SC_NUM, SC_IDENT, SC_STR, SC_CHAR_OPEN, SC_CHAR_CLOSE
  } scan_state_e;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [5:0] NO_PAIR = 6'h3f;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [7:0]             ch_i;
  logic                   last_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [5:0]             kind_o;
  logic [LINE_BITS-1:0]   line_o;
  logic [OFFSET_BITS-1:0] start_res_o;
  logic [LENGTH_BITS-1:0] length_o;
  logic [1:0]             error_o;
  logic                   done_res_o;

  source_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .line_o      (line_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .error_o     (error_o),
    .done_res_o  (done_res_o)
  );

  string kw_words [14] = '{"int", "char", "void", "const", "if", "else", "for",
                           "break", "continue", "return", "printf", "getint",
                           "getchar", "main"};
  string op_texts [25] = '{"+", "-", "*", "%", "/", "!", "!=", "&&", "||", "=",
                           "==", ">", ">=", "<", "<=", "(", ")", "[", "]", "{",
                           "}", ";", ",", "&", "|"};
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // Lexer state mirrored by the testbench.
  scan_state_e            scan_state;
  logic [LINE_BITS-1:0]   cur_line;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [LENGTH_BITS-1:0] tok_len;
  logic [7:0]             prev_ch;
  logic [63:0]            name_prefix;
  logic                   esc_pending;

  stok_res_t   pending_tokens [$];
  logic [7:0]  text_q [$];
  bit          burst_mode;
  int          fail_cnt;
  int          bytes_sent;
  int          buffers_sent;
  int          tokens_checked;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Software lexer
  // --------------------------------------------------------------------------
  function automatic void reset_lexer();
    scan_state  = SC_IDLE;
    cur_line    = 1;
    cur_offset  = '0;
    tok_start   = '0;
    tok_len     = '0;
    prev_ch     = '0;
    name_prefix = '0;
    esc_pending = 1'b0;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void push_token(logic [5:0] k, logic [OFFSET_BITS-1:0] st,
                                     logic [LENGTH_BITS-1:0] ln, logic [1:0] e,
                                     logic d);
    stok_res_t t;
    t.kind  = k;
    t.line  = cur_line;
    t.start = st;
    t.len   = ln;
    t.err   = e;
    t.done  = d;
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function automatic void grow_token();
    if (tok_len != '1) tok_len++;
  endfunction

  // A CR always counts; an LF counts unless it completes a CR LF pair.
  function automatic void count_break(logic [7:0] c);
    if ((c == CH_CR || (c == CH_LF && prev_ch != CH_CR)) && cur_line != '1)
      cur_line++;
  endfunction

  function automatic logic [63:0] kw_prefix(string s);
    logic [63:0] p;
    p = '0;
    for (int j = 0; j < s.len(); j++) p[8*j +: 8] = s[j];
    return p;
  endfunction

  function automatic logic [5:0] ident_kind();
    logic [5:0] k;
    k = K_IDENT;
    if (tok_len <= KW_CHARS) begin
      for (int i = 13; i >= 0; i--) begin
        if (name_prefix == kw_prefix(kw_words[i])) k = 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [5:0] op_pair(logic [7:0] first, logic [7:0] second);
    if (second == "=") begin
      if (first == "!") return K_NE;
      if (first == "=") return K_EQ;
      if (first == ">") return K_GE;
      if (first == "<") return K_LE;
    end
    if (first == "&" && second == "&") return K_AND;
    if (first == "|" && second == "|") return K_OR;
    return NO_PAIR;
  endfunction

  function automatic void push_single_op();
    logic [5:0] k;
    logic [1:0] e;
    e = ERR_NONE;
    case (prev_ch)
      "&": begin k = K_AND; e = ERR_AMP; end
      "|": begin k = K_OR; e = ERR_BAR; end
      "=": k = K_ASSIGN;
      ">": k = K_GT;
      "<": k = K_LT;
      default: k = K_NOT;
    endcase
    push_token(k, tok_start, 1, e, 1'b0);
  endfunction

  function automatic void scan_idle(logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
    logic [5:0] k;
    k = K_UNKNOWN;
    case (c)
      " ", CH_TAB, CH_BS: return;
      CH_CR, CH_LF: begin
        count_break(c);
        return;
      end
      "/": begin
        scan_state = SC_SLASH;
        tok_start  = pos;
        return;
      end
      "!", "&", "|", "=", ">", "<": begin
        scan_state = SC_OP;
        tok_start  = pos;
        return;
      end
      "\"": begin
        scan_state = SC_STR;
        tok_start  = pos;
        tok_len    = 1;
        return;
      end
      "'": begin
        scan_state  = SC_CHAR_OPEN;
        tok_start   = pos;
        tok_len     = 1;
        esc_pending = 1'b0;
        return;
      end
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "%": k = K_PCT;
      "(": k = K_LPAR;
      ")": k = K_RPAR;
      "[": k = K_LBRK;
      "]": k = K_RBRK;
      "{": k = K_LBRC;
      "}": k = K_RBRC;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      default: begin
        if (is_digit(c)) begin
          scan_state = SC_NUM;
          tok_start  = pos;
          tok_len    = 1;
          return;
        end
        if (is_alpha(c)) begin
          scan_state  = SC_IDENT;
          tok_start   = pos;
          tok_len     = 1;
          name_prefix = {56'd0, c};
          return;
        end
      end
    endcase
    push_token(k, pos, 1, ERR_NONE, 1'b0);
  endfunction

  // Advances the lexer by one byte and queues the tokens it completes.
  function automatic void scan_byte(logic [7:0] c, logic lst);
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] end_start;
    logic [1:0]             end_err;
    logic [5:0]             k;
    bit                     to_idle;
    bit                     clear_prev;
    pos        = cur_offset;
    to_idle    = 0;
    clear_prev = 0;
    case (scan_state)
      SC_NUM: begin
        if (is_digit(c)) grow_token();
        else begin
          push_token(K_NUM, tok_start, tok_len, ERR_NONE, 1'b0);
          to_idle = 1;
        end
      end
      SC_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (tok_len < KW_CHARS) name_prefix |= 64'(c) << (8 * tok_len);
          grow_token();
        end else begin
          push_token(ident_kind(), tok_start, tok_len, ERR_NONE, 1'b0);
          to_idle = 1;
        end
      end
      SC_OP: begin
        k = op_pair(prev_ch, c);
        if (k != NO_PAIR) begin
          push_token(k, tok_start, 2, ERR_NONE, 1'b0);
          scan_state = SC_IDLE;
        end else begin
          push_single_op();
          to_idle = 1;
        end
      end
      SC_SLASH: begin
        if (c == "/") scan_state = SC_LINE_CMT;
        else if (c == "*") scan_state = SC_BLOCK_CMT;
        else begin
          push_token(K_DIV, tok_start, 1, ERR_NONE, 1'b0);
          to_idle = 1;
        end
      end
      SC_LINE_CMT: if (c == CH_CR || c == CH_LF) to_idle = 1;
      SC_BLOCK_CMT, SC_BLOCK_STAR: begin
        if (scan_state == SC_BLOCK_STAR && c == "/") scan_state = SC_IDLE;
        else if (c == "*") scan_state = SC_BLOCK_STAR;
        else begin
          scan_state = SC_BLOCK_CMT;
          count_break(c);
        end
      end
      SC_STR: begin
        grow_token();
        if (c == "\"") begin
          push_token(K_STR, tok_start, tok_len, ERR_NONE, 1'b0);
          scan_state = SC_IDLE;
        end
      end
      SC_CHAR_OPEN: begin
        grow_token();
        esc_pending = (c == "\\");
        scan_state  = SC_CHAR_CLOSE;
      end
      SC_CHAR_CLOSE: begin
        grow_token();
        if (esc_pending) esc_pending = 1'b0;
        else begin
          push_token(K_CHR, tok_start, tok_len, ERR_NONE, 1'b0);
          scan_state = SC_IDLE;
          clear_prev = 1;
        end
      end
      default: to_idle = 1;
    endcase
    if (to_idle) begin
      scan_state = SC_IDLE;
      scan_idle(c, pos);
    end
    prev_ch = clear_prev ? 8'd0 : c;
    cur_offset++;

    if (lst) begin
      end_err   = ERR_NONE;
      end_start = cur_offset;
      case (scan_state)
        SC_NUM:   push_token(K_NUM, tok_start, tok_len, ERR_NONE, 1'b0);
        SC_IDENT: push_token(ident_kind(), tok_start, tok_len, ERR_NONE, 1'b0);
        SC_OP:    push_single_op();
        SC_SLASH: push_token(K_DIV, tok_start, 1, ERR_NONE, 1'b0);
        SC_BLOCK_CMT, SC_BLOCK_STAR, SC_STR, SC_CHAR_OPEN, SC_CHAR_CLOSE: begin
          end_err   = ERR_UNTERM;
          end_start = tok_start;
        end
        default: ;
      endcase
      push_token(K_END, end_start, 0, end_err, 1'b1);
      reset_lexer();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    b = $urandom_range(32, 126);
    if (b == "\"") b = "q";
    return b;
  endfunction

  function automatic void add_break();
    case ($urandom_range(0, 2))
      0: put_byte(CH_CR);
      1: put_byte(CH_LF);
      default: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
    endcase
  endfunction

  function automatic void add_blank();
    case ($urandom_range(0, 5))
      0, 1: put_byte(" ");
      2: put_byte(CH_TAB);
      3: put_byte(CH_BS);
      default: add_break();
    endcase
  endfunction

  function automatic void add_random_token();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: add_text(kw_words[$urandom_range(0, 13)]);
      3: begin
        // Keyword with a tail, so the prefix match has to reject it.
        add_text(kw_words[$urandom_range(0, 13)]);
        n = $urandom_range(1, 3);
        repeat (n) put_byte(pick_from(alnum_set));
      end
      4, 5: begin
        put_byte(pick_from(alpha_set));
        n = $urandom_range(0, 11);
        repeat (n) put_byte(pick_from(alnum_set));
      end
      6, 7: begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(8'($urandom_range(48, 57)));
      end
      8, 9, 10, 11: add_text(op_texts[$urandom_range(0, 24)]);
      12: begin
        put_byte("\"");
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) add_break();
          else put_byte(printable_byte());
        end
        put_byte("\"");
      end
      13: begin
        put_byte("'");
        if ($urandom_range(0, 2) == 0) put_byte("\\");
        put_byte(printable_byte());
        put_byte("'");
      end
      14: begin
        add_text("//");
        n = $urandom_range(0, 8);
        repeat (n) put_byte(printable_byte());
        add_break();
      end
      15: begin
        add_text("/*");
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) add_break();
          else put_byte(pick_from("ab */"));
        end
        add_text("*/");
      end
      16, 17: add_blank();
      default: put_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= ch;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_byte(ch, lst);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Sends the assembled text as one buffer, flagging its final byte.
  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    buffers_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // Number then identifier, lone ampersand and bar, CR LF, the extreme
    // byte values as unknown tokens and an escaped char constant.
    add_text("12ab& |");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'hff);
    add_text("'\\n'");
    put_byte(8'h00);
    send_buffer();
    // Open string and open block comment are flagged; an open line comment
    // is not.
    add_text("\"ab");
    send_buffer();
    add_text("/*");
    send_buffer();
    add_text("//");
    send_buffer();
    add_text("a<=");
    send_buffer();
  endtask

  task automatic test_random_streams();
    int start_bytes;
    int n;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 335) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      n = $urandom_range(2, 10);
      repeat (n) begin
        add_random_token();
        if ($urandom_range(0, 9) < 6) add_blank();
      end
      // Some buffers end in the middle of a construct.
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, text_q.size());
        while (text_q.size() > n) void'(text_q.pop_back());
      end
      send_buffer();
    end
    burst_mode = 0;
  endtask

  // --------------------------------------------------------------------------
  // Output side and checking
  // --------------------------------------------------------------------------
  initial begin : out_side
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_tokens
    stok_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        $error("token transfer with none expected: kind %0d, start %0d", kind_o,
               start_res_o);
        fail_cnt++;
      end else begin
        want = pending_tokens.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fail_cnt++;
        end
        if (line_o !== want.line) begin
          $error("line: expected %0d, got %0d", want.line, line_o);
          fail_cnt++;
        end
        if (start_res_o !== want.start) begin
          $error("start_res: expected %0d, got %0d", want.start, start_res_o);
          fail_cnt++;
        end
        if (length_o !== want.len) begin
          $error("length: expected %0d, got %0d", want.len, length_o);
          fail_cnt++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %0d, got %0d", want.err, error_o);
          fail_cnt++;
        end
        if (done_res_o !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, done_res_o);
          fail_cnt++;
        end
        tokens_checked++;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    ch_i         = '0;
    last_i       = 1'b0;
    burst_mode   = 0;
    fail_cnt     = 0;
    bytes_sent   = 0;
    buffers_sent = 0;
    tokens_checked = 0;
    reset_lexer();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_streams();
    in_valid_i <= 1'b0;

    for (int w = 0; w < 2000 && pending_tokens.size() != 0; w++) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", pending_tokens.size());
      fail_cnt++;
    end
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes in %0d buffers: directed corner cases, then random text,",
             bytes_sent, buffers_sent);
    $display("some buffers cut mid-construct; checked %0d tokens under random gaps.",
             tokens_checked);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
